// ===== hw/rtl/spht_pkg.sv =====
`default_nettype none
package spht_pkg;
	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int NUM_W    = 62;
	localparam int HANDLE_W = 16;
	localparam int LEVEL_W  = 2;

	typedef enum logic [1:0] {
		KIND_SEND   = 2'd0,
		KIND_MARK   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEND, S_SEARCH, S_APPLY, S_HEAD, S_OSTART, S_OLDEST, S_READ, S_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic do_send;
		logic scan_step;
		logic apply;
		logic head_step;
		logic old_start;
		logic old_step;
		logic num_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  scan_hit;
		logic  scan_end;
		logic  head_stop;
		logic  old_hit;
		logic  old_end;
		logic  out_free;
	} stat_t;

	// first member sits in the top bits
	typedef struct packed {
		logic [CNT_W-1:0]    entry_count;
		logic [CNT_W-1:0]    handshake_count;
		logic [CNT_W-1:0]    outstanding_count;
		logic [NUM_W-1:0]    oldest_number;
		logic                oldest_valid;
		logic [LEVEL_W-1:0]  hit_level;
		logic                hit_retransmittable;
		logic [HANDLE_W-1:0] hit_handle;
		status_t             status;
	} res_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		next_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/spht_ram.sv =====
`default_nettype none
module spht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/spht_ctrl.sv =====
`default_nettype none
module spht_ctrl import spht_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = S_SEARCH;
				end
			end
			S_SEND:   state_nx = S_OSTART;
			S_SEARCH: begin
				if (stat.scan_hit) begin
					state_nx = (stat.kind == KIND_LOOKUP) ? S_OSTART : S_APPLY;
				end else if (stat.scan_end) begin
					state_nx = S_OSTART;
				end
			end
			S_APPLY:  state_nx = (stat.kind == KIND_REMOVE) ? S_HEAD : S_OSTART;
			S_HEAD: begin
				if (stat.head_stop) begin
					state_nx = S_OSTART;
				end
			end
			S_OSTART: state_nx = S_OLDEST;
			S_OLDEST: begin
				if (stat.old_hit || stat.old_end) begin
					state_nx = S_READ;
				end
			end
			S_READ:   state_nx = S_WAIT;
			S_WAIT: begin
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default:  state_nx = S_IDLE;
		endcase
		// kind is only known after the item is registered
		if (state_q == S_SEARCH && stat.kind == KIND_SEND) begin
			state_nx = S_SEND;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SEND:   cmd.do_send   = 1'b1;
			S_SEARCH: cmd.scan_step = (stat.kind != KIND_SEND);
			S_APPLY:  cmd.apply     = 1'b1;
			S_HEAD:   cmd.head_step = 1'b1;
			S_OSTART: cmd.old_start = 1'b1;
			S_OLDEST: cmd.old_step  = 1'b1;
			S_READ:   cmd.num_read  = 1'b1;
			S_WAIT: begin
				// hold the oldest-number read while the result waits
				cmd.num_read = 1'b1;
				cmd.out_load = stat.out_free;
			end
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/spht_dp.sv =====
`default_nettype none
module spht_dp import spht_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  wire [1:0]           in_kind,
	input  wire [NUM_W-1:0]     in_number,
	input  wire [HANDLE_W-1:0]  in_handle,
	input  wire                 in_retx,
	input  wire [LEVEL_W-1:0]   in_level,
	input  wire [LEVEL_W-1:0]   fs_level,
	output res_t                res,
	output logic                res_valid,
	input  wire                 res_ready
);
	kind_t               kind_q;
	logic [NUM_W-1:0]    pn_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                retx_q;
	logic [LEVEL_W-1:0]  level_q;

	logic [DEPTH-1:0]    used_q;
	logic [DEPTH-1:0]    retx_flag_q;
	logic [IDX_W-1:0]    head_q, tail_q, oldest_q;
	logic [CNT_W-1:0]    held_q, retx_cnt_q, hs_cnt_q;
	logic                present_q;

	logic [IDX_W-1:0]    scan_idx_q, cmp_idx_s1, slot_q, old_idx_q;
	logic [CNT_W-1:0]    scan_n_q, old_n_q;
	logic                cmp_v_s1;

	status_t             status_q;
	logic [HANDLE_W-1:0] hit_handle_q;
	logic                hit_retx_q;
	logic [LEVEL_W-1:0]  hit_level_q;
	logic                res_valid_q;

	logic [IDX_W-1:0]    rd_addr;
	logic                ram_we;
	logic [NUM_W-1:0]    num_rdata;
	logic [HANDLE_W-1:0] handle_rdata;
	logic [LEVEL_W-1:0]  level_rdata;
	logic                retx_under, hs_under, drop_hs;

	assign rd_addr = cmd.num_read ? oldest_q : scan_idx_q;
	assign ram_we  = cmd.do_send && !used_q[tail_q];

	spht_ram #(.WIDTH(NUM_W), .DEPTH(DEPTH)) u_num_ram (
		.clk(clk), .we(ram_we), .waddr(tail_q), .wdata(pn_q),
		.raddr(rd_addr), .rdata(num_rdata)
	);
	spht_ram #(.WIDTH(HANDLE_W), .DEPTH(DEPTH)) u_handle_ram (
		.clk(clk), .we(ram_we), .waddr(tail_q), .wdata(handle_q),
		.raddr(rd_addr), .rdata(handle_rdata)
	);
	spht_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_level_ram (
		.clk(clk), .we(ram_we), .waddr(tail_q), .wdata(level_q),
		.raddr(rd_addr), .rdata(level_rdata)
	);

	assign stat.kind      = kind_q;
	assign stat.scan_hit  = cmp_v_s1 && used_q[cmp_idx_s1] && (num_rdata == pn_q);
	assign stat.scan_end  = !cmp_v_s1 && (scan_n_q == CNT_W'(DEPTH));
	assign stat.head_stop = (head_q == tail_q) || used_q[head_q];
	assign stat.old_hit   = (old_n_q != CNT_W'(DEPTH)) && used_q[old_idx_q]
		&& retx_flag_q[old_idx_q];
	assign stat.old_end   = (old_n_q == CNT_W'(DEPTH));
	assign stat.out_free  = !res_valid_q || res_ready;

	assign drop_hs    = hit_level_q < fs_level;
	assign retx_under = (retx_cnt_q == '0);
	assign hs_under   = drop_hs && (hs_cnt_q == '0);

	// item registers and search datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q       <= kind_t'(in_kind);
			pn_q         <= in_number;
			handle_q     <= in_handle;
			retx_q       <= in_retx;
			level_q      <= in_level;
			scan_idx_q   <= head_q;
			scan_n_q     <= '0;
			cmp_v_s1     <= 1'b0;
			status_q     <= ST_OK;
			hit_handle_q <= '0;
			hit_retx_q   <= 1'b0;
			hit_level_q  <= '0;
		end
		if (cmd.scan_step) begin
			cmp_idx_s1 <= scan_idx_q;
			cmp_v_s1   <= (scan_n_q != CNT_W'(DEPTH));
			if (scan_n_q != CNT_W'(DEPTH)) begin
				scan_idx_q <= next_idx(scan_idx_q);
				scan_n_q   <= scan_n_q + 1'b1;
			end
			if (stat.scan_hit) begin
				slot_q      <= cmp_idx_s1;
				hit_retx_q  <= retx_flag_q[cmp_idx_s1];
				hit_level_q <= level_rdata;
				if (kind_q == KIND_LOOKUP) begin
					hit_handle_q <= handle_rdata;
				end
			end else if (stat.scan_end) begin
				status_q <= ST_NOT_FOUND;
			end
		end
		if (cmd.do_send && used_q[tail_q]) begin
			status_q <= ST_FULL;
		end
		if (cmd.apply && hit_retx_q && (retx_under || hs_under)) begin
			status_q <= ST_UNDERFLOW;
		end
		if (cmd.do_send && !used_q[tail_q]) begin
			retx_flag_q[tail_q] <= retx_q;
		end
		if (cmd.apply && kind_q == KIND_MARK) begin
			retx_flag_q[slot_q] <= 1'b0;
		end
		if (cmd.old_start) begin
			old_idx_q <= head_q;
			old_n_q   <= '0;
		end else if (cmd.old_step && !stat.old_hit && !stat.old_end) begin
			old_idx_q <= next_idx(old_idx_q);
			old_n_q   <= old_n_q + 1'b1;
		end
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			retx_cnt_q  <= '0;
			hs_cnt_q    <= '0;
			oldest_q    <= '0;
			present_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.do_send && !used_q[tail_q]) begin
				used_q[tail_q] <= 1'b1;
				if (held_q == '0) begin
					head_q <= tail_q;
				end
				held_q <= held_q + 1'b1;
				tail_q <= next_idx(tail_q);
				if (retx_q) begin
					retx_cnt_q <= retx_cnt_q + 1'b1;
					if (level_q < fs_level) begin
						hs_cnt_q <= hs_cnt_q + 1'b1;
					end
				end
			end
			if (cmd.apply && kind_q != KIND_LOOKUP) begin
				if (hit_retx_q) begin
					if (!retx_under) begin
						retx_cnt_q <= retx_cnt_q - 1'b1;
					end
					if (drop_hs && !hs_under) begin
						hs_cnt_q <= hs_cnt_q - 1'b1;
					end
				end
				if (kind_q == KIND_REMOVE) begin
					used_q[slot_q] <= 1'b0;
					if (held_q != '0) begin
						held_q <= held_q - 1'b1;
					end
				end
			end
			if (cmd.head_step && !stat.head_stop) begin
				head_q <= next_idx(head_q);
			end
			if (cmd.old_start) begin
				present_q <= 1'b0;
				oldest_q  <= '0;
			end else if (cmd.old_step && stat.old_hit) begin
				present_q <= 1'b1;
				oldest_q  <= old_idx_q;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.status              <= status_q;
			res.hit_handle          <= hit_handle_q;
			res.hit_retransmittable <= hit_retx_q;
			res.hit_level           <= hit_level_q;
			res.oldest_valid        <= present_q;
			res.oldest_number       <= present_q ? num_rdata : '0;
			res.outstanding_count   <= retx_cnt_q;
			res.handshake_count     <= hs_cnt_q;
			res.entry_count         <= held_q;
		end
	end

	assign res_valid = res_valid_q;
endmodule
`default_nettype wire

// ===== hw/rtl/sent_packet_history_table_top.sv =====
// Each item: a send skips the search; other kinds search over the ring,
// a remove then walks the head, and every item ends with the oldest-entry walk,
// one slot a cycle each; the result may then wait on m_axis_tready.
// Throughput: one item at a time; the next item is taken the cycle after the result is registered.
// Reset: arst_n asynchronous, active low; clears used flags, indices, counts,
// sets forward_secure_level to 2. Entry contents stay undefined until written.
`default_nettype none
module sent_packet_history_table_top import spht_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// pkt number, handle, retransmittable, level, zero pad
	input  wire [87:0]   s_axis_tdata,
	// kind
	input  wire [1:0]    s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// status, hit_handle, hit_retransmittable, hit_level, oldest_valid,
	// oldest_number, outstanding_count, handshake_count, entry_count, zero pad
	output logic [111:0] m_axis_tdata,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire [2:0]    paddr,
	input  wire [31:0]   pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam logic REG_FS_LEVEL = 1'b0;

	logic [LEVEL_W-1:0] fs_level_q;
	cmd_t               cmd;
	stat_t              stat;
	res_t               res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FS_LEVEL) ? {30'd0, fs_level_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_level_q <= 2'd2;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FS_LEVEL) begin
			fs_level_q <= pwdata[1:0];
		end
	end

	spht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	spht_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_kind(s_axis_tuser),
		.in_number(s_axis_tdata[61:0]),
		.in_handle(s_axis_tdata[77:62]),
		.in_retx(s_axis_tdata[78]),
		.in_level(s_axis_tdata[80:79]),
		.fs_level(fs_level_q),
		.res(res), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {7'd0, res};

	a_retx_le_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.outstanding_count <= res.entry_count)
		else $error("outstanding count above entry count");

	a_oldest_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.oldest_valid |-> res.outstanding_count != '0)
		else $error("oldest entry reported with no outstanding packets");

	a_count_has_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.outstanding_count != '0 |-> res.oldest_valid)
		else $error("outstanding packets without oldest entry");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in flight");
endmodule
`default_nettype wire
